/* hw/rtl/stms_pkg.sv */
// Package for the stepper move sequencer: opcodes, status codes, run modes
// and configuration register indexes. No dependencies.
`default_nettype none

package stms_pkg;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_STEP     = 3'd1;
  localparam logic [2:0] OP_MOVE_CNT = 3'd2;
  localparam logic [2:0] OP_MOVE_REL = 3'd3;
  localparam logic [2:0] OP_MOVE_TO  = 3'd4;
  localparam logic [2:0] OP_HOME     = 3'd5;
  localparam logic [2:0] OP_SET_POS  = 3'd6;
  localparam logic [2:0] OP_STOP     = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BOUNDS  = 2'd1;
  localparam logic [1:0] ST_AT_TGT  = 2'd2;
  localparam logic [1:0] ST_BUSY    = 2'd3;

  localparam logic [1:0] RUN_IDLE    = 2'd0;
  localparam logic [1:0] RUN_MOVE    = 2'd1;
  localparam logic [1:0] RUN_SEEK    = 2'd2;
  localparam logic [1:0] RUN_RELEASE = 2'd3;

  localparam logic [2:0] CFG_STEP_MODE  = 3'd0;
  localparam logic [2:0] CFG_INVERT_DIR = 3'd1;
  localparam logic [2:0] CFG_STEP_DELAY = 3'd2;
  localparam logic [2:0] CFG_MIN_POS    = 3'd3;
  localparam logic [2:0] CFG_MAX_POS    = 3'd4;
  localparam logic [2:0] CFG_LIMIT_LVL  = 3'd5;
  localparam logic [2:0] CFG_FULL_TBL   = 3'd6;
  localparam logic [2:0] CFG_HALF_TBL   = 3'd7;

  localparam logic [15:0] FULL_TBL_RST = 16'd40035;
  localparam logic [31:0] HALF_TBL_RST = 32'd2563007025;

endpackage

`default_nettype wire

/* hw/rtl/stms_if.sv */
// Handshake interfaces for the stepper move sequencer: command requests,
// result requests and configuration writes. No dependencies.
`default_nettype none

interface stms_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic               direction;
  logic signed [31:0] amount;
  logic               limit_switch;
  modport source (output valid, opcode, direction, amount, limit_switch, input ready);
  modport sink   (input valid, opcode, direction, amount, limit_switch, output ready);
endinterface

interface stms_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coils;
  logic signed [31:0] position;
  logic               busy_res;
  logic [1:0]         status;
  logic               done_res;
  modport source (output valid, coils, position, busy_res, status, done_res, input ready);
  modport sink   (input valid, coils, position, busy_res, status, done_res, output ready);
endinterface

interface stms_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stepper_move_sequencer.sv */
// Stepper move sequencer top level: commands pass the command register, then
// the result register; one request accepted per cycle when results are taken.
// The command register feeds one stage of logic that updates the motion state
// and loads the result register; the result register sets the throughput.
// Reset (asynchronous, active low) idles the run, clears position and coils
// and loads the configuration registers with their defaults.
`default_nettype none

module stepper_move_sequencer
  import stms_pkg::*;
#(
  parameter int RELEASE_STEPS = 50,
  parameter int POSITION_BITS = 32,
  parameter int DELAY_BITS    = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  stms_cmd_if.sink   cmd_i,
  stms_cfg_if.sink   cfg_i,
  stms_res_if.source res_o
);

  localparam int PB = POSITION_BITS;
  localparam int SW = ((PB > 32) ? PB : 32) + 2;

  // Configuration registers.
  logic               step_mode_q;
  logic               invert_dir_q;
  logic [31:0]        step_delay_q;
  logic signed [31:0] min_pos_q;
  logic signed [31:0] max_pos_q;
  logic               limit_lvl_q;
  logic [15:0]        full_tbl_q;
  logic [31:0]        half_tbl_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_mode_q  <= 1'b0;
      invert_dir_q <= 1'b0;
      step_delay_q <= 32'd1000;
      min_pos_q    <= 32'sh8000_0000;
      max_pos_q    <= 32'sh7FFF_FFFF;
      limit_lvl_q  <= 1'b0;
      full_tbl_q   <= FULL_TBL_RST;
      half_tbl_q   <= HALF_TBL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_STEP_MODE:  step_mode_q  <= cfg_i.data[0];
        CFG_INVERT_DIR: invert_dir_q <= cfg_i.data[0];
        CFG_STEP_DELAY: step_delay_q <= cfg_i.data;
        CFG_MIN_POS:    min_pos_q    <= $signed(cfg_i.data);
        CFG_MAX_POS:    max_pos_q    <= $signed(cfg_i.data);
        CFG_LIMIT_LVL:  limit_lvl_q  <= cfg_i.data[0];
        CFG_FULL_TBL:   full_tbl_q   <= cfg_i.data[15:0];
        CFG_HALF_TBL:   half_tbl_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Command register.
  logic               in_vld_q;
  logic [2:0]         op_q;
  logic               dir_q;
  logic signed [31:0] amt_q;
  logic               sw_q;
  logic               out_vld_q;
  logic               adv;
  logic               fire;

  assign adv         = !out_vld_q || res_o.ready;
  assign fire        = in_vld_q && adv;
  assign cmd_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (cmd_i.valid && cmd_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      op_q  <= cmd_i.opcode;
      dir_q <= cmd_i.direction;
      amt_q <= cmd_i.amount;
      sw_q  <= cmd_i.limit_switch;
    end
  end

  // Motion state.
  logic [2:0]            phase_q, phase_d;
  logic [PB-1:0]         pos_q, pos_d;
  logic [31:0]           steps_q, steps_d;
  logic [DELAY_BITS-1:0] delay_q, delay_d;
  logic                  fwd_q, fwd_d;
  logic [1:0]            run_q, run_d;
  logic [3:0]            coil_q, coil_d;

  // Bounds arithmetic, one add or subtract and compares each.
  logic signed [SW-1:0] p_w, amt_w, lo_w, hi_w, sum_w, diff_w, mag_w;
  logic [31:0]          dist_sat;
  logic [31:0]          amt_abs;

  assign p_w      = SW'($signed(pos_q));
  assign amt_w    = SW'(amt_q);
  assign lo_w     = SW'(min_pos_q);
  assign hi_w     = SW'(max_pos_q);
  assign sum_w    = p_w + amt_w;
  assign diff_w   = amt_w - p_w;
  assign mag_w    = (diff_w < 0) ? -diff_w : diff_w;
  assign dist_sat = (mag_w[SW-1:32] != '0) ? 32'hFFFF_FFFF : mag_w[31:0];
  assign amt_abs  = amt_q[31] ? 32'(-amt_w) : 32'(amt_q);

  logic       step_en;    // phase advance only
  logic       move_en;    // phase advance plus position and delay reload
  logic       step_fwd;
  logic [1:0] status;
  logic       done;
  logic       busy;
  logic       sw_hit;
  logic       due;
  logic [DELAY_BITS-1:0] delay_dec;
  logic       ph_fwd;
  logic [2:0] ph_next;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    steps_d  = steps_q;
    delay_d  = delay_q;
    fwd_d    = fwd_q;
    run_d    = run_q;
    coil_d   = coil_q;
    step_en  = 1'b0;
    move_en  = 1'b0;
    step_fwd = 1'b0;
    status   = ST_OK;
    done     = 1'b0;
    busy     = (run_q != RUN_IDLE);
    sw_hit   = (sw_q == limit_lvl_q);
    delay_dec = delay_q - 1'b1;
    due      = (delay_q == '0) || (delay_dec == '0);

    case (op_q)
      OP_STOP: begin
        done    = busy;
        run_d   = RUN_IDLE;
        steps_d = '0;
        delay_d = '0;
        coil_d  = 4'b0000;
      end
      OP_TICK: begin
        if (busy) begin
          if (delay_q != '0) begin
            delay_d = delay_dec;
          end
          if (due) begin
            if (run_q == RUN_SEEK) begin
              move_en = 1'b1;
              if (sw_hit) begin
                // Limit reached: back off the other way.
                step_fwd = !fwd_q;
                fwd_d    = !fwd_q;
                steps_d  = 32'(RELEASE_STEPS - 1);
                run_d    = RUN_RELEASE;
              end else begin
                step_fwd = fwd_q;
              end
            end else if (steps_q != '0) begin
              steps_d  = steps_q - 1'b1;
              move_en  = 1'b1;
              step_fwd = fwd_q;
            end else begin
              coil_d = 4'b0000;
              run_d  = RUN_IDLE;
              done   = 1'b1;
            end
          end
        end
      end
      default: begin
        if (busy) begin
          status = ST_BUSY;
        end else begin
          case (op_q)
            OP_STEP: begin
              step_en  = 1'b1;
              step_fwd = dir_q;
            end
            OP_MOVE_CNT: begin
              if (amt_abs == '0) begin
                coil_d = 4'b0000;
                done   = 1'b1;
              end else begin
                move_en  = 1'b1;
                step_fwd = dir_q;
                fwd_d    = dir_q;
                steps_d  = amt_abs - 1'b1;
                run_d    = RUN_MOVE;
              end
            end
            OP_MOVE_REL: begin
              if (amt_q == '0) begin
                status = ST_AT_TGT;
              end else if (sum_w < lo_w || sum_w > hi_w) begin
                status = ST_BOUNDS;
              end else begin
                move_en  = 1'b1;
                step_fwd = !amt_q[31];
                fwd_d    = !amt_q[31];
                steps_d  = amt_abs - 1'b1;
                run_d    = RUN_MOVE;
              end
            end
            OP_MOVE_TO: begin
              if (amt_w < lo_w || amt_w > hi_w) begin
                status = ST_BOUNDS;
              end else if (diff_w == '0) begin
                status = ST_AT_TGT;
              end else begin
                move_en  = 1'b1;
                step_fwd = (diff_w > 0);
                fwd_d    = (diff_w > 0);
                steps_d  = dist_sat - 1'b1;
                run_d    = RUN_MOVE;
              end
            end
            OP_HOME: begin
              move_en = 1'b1;
              if (sw_hit) begin
                step_fwd = !dir_q;
                fwd_d    = !dir_q;
                steps_d  = 32'(RELEASE_STEPS - 1);
                run_d    = RUN_RELEASE;
              end else begin
                step_fwd = dir_q;
                fwd_d    = dir_q;
                steps_d  = '0;
                run_d    = RUN_SEEK;
              end
            end
            OP_SET_POS: begin
              pos_d = PB'(amt_w);
            end
            default: ;
          endcase
        end
      end
    endcase

    // Shared phase stepper; the full-step table uses the index modulo four.
    ph_fwd  = step_fwd ^ invert_dir_q;
    ph_next = '0;
    if (step_mode_q) begin
      ph_next = ph_fwd ? (phase_q + 3'd1) : (phase_q - 3'd1);
    end else begin
      ph_next = {1'b0, ph_fwd ? (phase_q[1:0] + 2'd1) : (phase_q[1:0] - 2'd1)};
    end
    if (step_en || move_en) begin
      phase_d = ph_next;
      coil_d  = step_mode_q ? half_tbl_q[4*ph_next +: 4] : full_tbl_q[4*ph_next[1:0] +: 4];
    end
    if (move_en) begin
      pos_d   = step_fwd ? (pos_q + 1'b1) : (pos_q - 1'b1);
      delay_d = step_delay_q[DELAY_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      pos_q   <= '0;
      steps_q <= '0;
      delay_q <= '0;
      fwd_q   <= 1'b0;
      run_q   <= RUN_IDLE;
      coil_q  <= 4'b0000;
    end else if (fire) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      steps_q <= steps_d;
      delay_q <= delay_d;
      fwd_q   <= fwd_d;
      run_q   <= run_d;
      coil_q  <= coil_d;
    end
  end

  // Result register.
  logic [3:0]  res_coils_q;
  logic [31:0] res_pos_q;
  logic        res_busy_q;
  logic [1:0]  res_status_q;
  logic        res_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_coils_q  <= coil_d;
      res_pos_q    <= 32'(pos_d);
      res_busy_q   <= (run_d != RUN_IDLE);
      res_status_q <= status;
      res_done_q   <= done;
    end
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.coils    = res_coils_q;
  assign res_o.position = $signed(res_pos_q);
  assign res_o.busy_res = res_busy_q;
  assign res_o.status   = res_status_q;
  assign res_o.done_res = res_done_q;

endmodule

`default_nettype wire
